// ----- rtl/core/tpm_pkg.sv -----
// ----------------------------------------------------------------------------
// tpm_pkg
// Shared types, widths and elaboration-time coefficient generation for the
// polyphase true-peak meter.
// ----------------------------------------------------------------------------
package tpm_pkg;

    // default build parameters
    localparam int TAPS_DEF     = 49;
    localparam int UPSAMPLE_DEF = 4;

    // largest supported oversampling factor and phase index width
    localparam int MAX_UP = 8;
    localparam int PH_W   = 3;

    // datapath widths
    localparam int SAMPLE_W = 24;
    localparam int TP_W     = 25;
    localparam int SP_W     = 24;
    localparam int COEF_W   = 18;
    localparam int PROD_W   = 42;

    // rounding shift and saturation limit of the true peak (Q2.23)
    localparam int          RND_SHIFT = 16;
    localparam logic [TP_W-1:0] TP_MAX = {TP_W{1'b1}};

    // pi in Q30
    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    // control state
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    // phase tag that travels along the cell chain with each partial sum
    typedef struct packed {
        logic            vld;
        logic [PH_W-1:0] phase;
    } t_tag;

    // restoring long division, used at elaboration only
    function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // sin(pi*m/up) in Q30 by an eleven-term series
    function automatic logic [63:0] sine_q30(input logic [63:0] m, input logic [63:0] up);
        logic [63:0]        x;
        logic [63:0]        t;
        logic signed [63:0] s;
        x = udiv(PI_Q30 * m + (up >> 1), up);
        t = x;
        s = $signed(x);
        for (int n = 1; n <= 10; n++) begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = udiv(t, 64'((2 * n) * (2 * n + 1)));
            if ((n % 2) == 1) begin
                s = s - $signed(t);
            end else begin
                s = s + $signed(t);
            end
        end
        return (s < 0) ? 64'd0 : 64'(s);
    endfunction

    // windowless sinc coefficient c of a taps-long filter, Q2.16
    function automatic logic signed [COEF_W-1:0] coef_value(input int c, input int taps,
                                                           input int up);
        int                 centre;
        int                 k;
        logic [63:0]        a;
        logic [63:0]        m;
        logic [63:0]        s;
        logic [63:0]        num;
        logic [63:0]        den;
        logic [63:0]        q;
        logic signed [63:0] r;
        logic               neg;
        centre = (taps - 1) >> 1;
        k      = c - centre;
        neg    = 1'b0;
        r      = '0;
        if (c >= taps) begin
            r = '0;
        end else if (k == 0) begin
            r = 64'sd65536;
        end else begin
            a = 64'((k < 0) ? -k : k);
            if (a > 64'(centre)) begin
                r = '0;
            end else begin
                m = a - udiv(a, 64'(2 * up)) * 64'(2 * up);
                if (m >= 64'(up)) begin
                    m   = m - 64'(up);
                    neg = 1'b1;
                end
                if (2 * m > 64'(up)) begin
                    m = 64'(up) - m;
                end
                s   = sine_q30(m, 64'(up));
                num = (64'(up) * s) << 16;
                den = PI_Q30 * a;
                q   = udiv(2 * num + den, 2 * den);
                r   = neg ? -$signed(q) : $signed(q);
            end
        end
        return r[COEF_W-1:0];
    endfunction

endpackage

// ----- rtl/core/tpm_cell.sv -----
// ----------------------------------------------------------------------------
// tpm_cell
// One tap cell: holds one history sample and its polyphase coefficients,
// adds its product to the partial sum passing through.
// ----------------------------------------------------------------------------
module tpm_cell #(
    parameter int TAPS     = tpm_pkg::TAPS_DEF,
    parameter int UPSAMPLE = tpm_pkg::UPSAMPLE_DEF,
    parameter int CELL_IDX = 0,
    parameter int ACC_W    = tpm_pkg::PROD_W + 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_shift,
    input  logic signed [tpm_pkg::SAMPLE_W-1:0] i_hist,
    output logic signed [tpm_pkg::SAMPLE_W-1:0] o_hist,
    input  logic signed [ACC_W-1:0]             i_sum,
    input  tpm_pkg::t_tag                       i_tag,
    output logic signed [ACC_W-1:0]             o_sum,
    output tpm_pkg::t_tag                       o_tag
);

    logic signed [tpm_pkg::COEF_W-1:0]   w_coef [tpm_pkg::MAX_UP];
    logic signed [tpm_pkg::PROD_W-1:0]   w_prod;
    logic signed [tpm_pkg::SAMPLE_W-1:0] r_hist;
    logic signed [tpm_pkg::PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]             r_sum_d;
    logic signed [ACC_W-1:0]             r_sum;
    tpm_pkg::t_tag                       r_tag_d;
    tpm_pkg::t_tag                       r_tag;

    // constant coefficient table, one entry per phase
    for (genvar gp = 0; gp < tpm_pkg::MAX_UP; gp++) begin : g_coef
        localparam logic signed [tpm_pkg::COEF_W-1:0] CoefV = (gp < UPSAMPLE) ?
            tpm_pkg::coef_value(gp + CELL_IDX * UPSAMPLE, TAPS, UPSAMPLE) : '0;
        assign w_coef[gp] = CoefV;
    end

    // tap product for the phase arriving now
    assign w_prod = w_coef[i_tag.phase] * r_hist;

    // history and tag registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist  <= '0;
            r_tag_d <= '0;
            r_tag   <= '0;
        end else begin
            if (i_shift) begin
                r_hist <= i_hist;
            end
            r_tag_d <= i_tag;
            r_tag   <= r_tag_d;
        end
    end

    // product stage then accumulate stage
    always_ff @(posedge i_clk) begin
        r_prod  <= w_prod;
        r_sum_d <= i_sum;
        r_sum   <= r_sum_d
                 + {{(ACC_W - tpm_pkg::PROD_W){r_prod[tpm_pkg::PROD_W-1]}}, r_prod};
    end

    assign o_hist = r_hist;
    assign o_sum  = r_sum;
    assign o_tag  = r_tag;

endmodule

// ----- rtl/core/tpm_peak.sv -----
// ----------------------------------------------------------------------------
// tpm_peak
// Magnitude, rounding and saturation of each interpolated value, and the
// running true-peak and sample-peak maxima.
// ----------------------------------------------------------------------------
module tpm_peak #(
    parameter int ACC_W = tpm_pkg::PROD_W + 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic signed [ACC_W-1:0]         i_sum,
    input  logic                            i_sum_vld,
    input  logic [tpm_pkg::SP_W-1:0]        i_smag,
    input  logic                            i_smag_vld,
    output logic [tpm_pkg::TP_W-1:0]        o_true_peak,
    output logic [tpm_pkg::SP_W-1:0]        o_sample_peak,
    output logic                            o_upd
);

    localparam int RndW = ACC_W + 1 - tpm_pkg::RND_SHIFT;

    logic [ACC_W-1:0]         w_abs;
    logic [ACC_W:0]           w_rnd_full;
    logic [RndW-1:0]          w_rnd;
    logic [tpm_pkg::TP_W-1:0] w_sat;
    logic [tpm_pkg::TP_W-1:0] w_smag_tp;
    logic [ACC_W-1:0]         r_mag;
    logic                     r_mag_vld;
    logic [tpm_pkg::TP_W-1:0] r_tp;
    logic [tpm_pkg::TP_W-1:0] n_tp;
    logic [tpm_pkg::SP_W-1:0] r_sp;
    logic [tpm_pkg::SP_W-1:0] n_sp;

    // magnitude of the accumulated sum
    assign w_abs = i_sum[ACC_W-1] ? ACC_W'(-i_sum) : ACC_W'(i_sum);

    // round half up to Q.23 and clamp to the peak range
    assign w_rnd_full = {1'b0, r_mag} + (ACC_W+1)'(1 << (tpm_pkg::RND_SHIFT - 1));
    assign w_rnd      = w_rnd_full[ACC_W:tpm_pkg::RND_SHIFT];
    assign w_sat      = (w_rnd > RndW'(tpm_pkg::TP_MAX)) ? tpm_pkg::TP_MAX
                                                        : w_rnd[tpm_pkg::TP_W-1:0];
    assign w_smag_tp  = {1'b0, i_smag};

    // running maxima
    always_comb begin
        n_tp = r_tp;
        n_sp = r_sp;
        if (r_mag_vld && (w_sat > n_tp)) begin
            n_tp = w_sat;
        end
        if (i_smag_vld && (w_smag_tp > n_tp)) begin
            n_tp = w_smag_tp;
        end
        if (i_smag_vld && (i_smag > r_sp)) begin
            n_sp = i_smag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag_vld <= 1'b0;
            r_tp      <= '0;
            r_sp      <= '0;
        end else begin
            r_mag_vld <= i_sum_vld;
            r_tp      <= n_tp;
            r_sp      <= n_sp;
        end
    end

    // magnitude register
    always_ff @(posedge i_clk) begin
        r_mag <= w_abs;
    end

    assign o_true_peak   = r_tp;
    assign o_sample_peak = r_sp;
    assign o_upd         = r_mag_vld;

endmodule

// ----- rtl/core/true_peak_meter_polyphase.sv -----
// ----------------------------------------------------------------------------
// true_peak_meter_polyphase
// Polyphase sinc-interpolating true-peak and sample-peak meter.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready / i_sample) takes one signed Q1.23
//   sample per transfer. o_ready is high only while the block is idle.
//   Output channel (o_valid / i_ready / o_true_peak / o_sample_peak) gives
//   one result per input sample: the running true peak (Q2.23, saturating)
//   and running sample peak (Q1.23).
//   Each sample is shifted into a chain of ceil(TAPS/UPSAMPLE) tap cells;
//   the UPSAMPLE phases are issued into the chain on consecutive cycles and
//   each cell passes a partial sum through a multiply register, then an
//   add register. The block takes no new sample before it is through with
//   the last: o_ready rises again only after the result of the previous
//   sample has been loaded into the output register.
//   Reset clears the history, both peaks and the output register.
//   The result sits in an output register: when the receiver stalls, the
//   block still accepts and processes the next sample, then waits with o_ready
//   low until the held result has been transferred.
// ----------------------------------------------------------------------------
module true_peak_meter_polyphase #(
    parameter int TAPS     = tpm_pkg::TAPS_DEF,
    parameter int UPSAMPLE = tpm_pkg::UPSAMPLE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [tpm_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [tpm_pkg::TP_W-1:0]            o_true_peak,
    output logic [tpm_pkg::SP_W-1:0]            o_sample_peak
);

    localparam int HistLen = (TAPS + UPSAMPLE - 1) / UPSAMPLE;
    localparam int AccW    = tpm_pkg::PROD_W + $clog2(HistLen + 1);

    logic signed [tpm_pkg::SAMPLE_W-1:0] w_hist [HistLen];
    logic signed [AccW-1:0]              w_sum  [HistLen];
    tpm_pkg::t_tag                       w_tag  [HistLen];
    tpm_pkg::t_tag                       w_issue_tag;
    logic                                w_in_xfer;
    logic                                w_issue;
    logic                                w_load_out;
    logic                                w_last_upd;
    logic                                w_upd;
    logic [tpm_pkg::SP_W-1:0]            w_smag;
    logic [tpm_pkg::TP_W-1:0]            w_tp;
    logic [tpm_pkg::SP_W-1:0]            w_sp;

    tpm_pkg::t_state                     r_state;
    tpm_pkg::t_state                     n_state;
    logic [tpm_pkg::PH_W-1:0]            r_phase;
    logic                                r_issue_on;
    logic [tpm_pkg::PH_W:0]              r_done_cnt;
    logic                                r_o_valid;
    logic [tpm_pkg::TP_W-1:0]            r_tp_out;
    logic [tpm_pkg::SP_W-1:0]            r_sp_out;

    // input transfer and raw sample magnitude
    assign w_in_xfer = i_valid && o_ready;
    assign w_smag    = i_sample[tpm_pkg::SAMPLE_W-1] ? tpm_pkg::SP_W'(-i_sample)
                                                     : tpm_pkg::SP_W'(i_sample);

    // last phase of this sample reaches the peak registers
    assign w_last_upd = w_upd && (r_done_cnt == (tpm_pkg::PH_W+1)'(UPSAMPLE - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tpm_pkg::ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = tpm_pkg::ST_RUN;
                end
            end
            tpm_pkg::ST_RUN: begin
                if (w_last_upd) begin
                    n_state = tpm_pkg::ST_DONE;
                end
            end
            tpm_pkg::ST_DONE: begin
                if (!r_o_valid || i_ready) begin
                    n_state = tpm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tpm_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_ready    = 1'b0;
        w_issue    = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            tpm_pkg::ST_IDLE: begin
                o_ready = 1'b1;
            end
            tpm_pkg::ST_RUN: begin
                w_issue = r_issue_on;
            end
            tpm_pkg::ST_DONE: begin
                w_load_out = !r_o_valid || i_ready;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tpm_pkg::ST_IDLE;
            r_phase    <= '0;
            r_issue_on <= 1'b0;
            r_done_cnt <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            // phase issue counter
            if (w_in_xfer) begin
                r_phase    <= '0;
                r_issue_on <= 1'b1;
            end else if (w_issue) begin
                if (r_phase == tpm_pkg::PH_W'(UPSAMPLE - 1)) begin
                    r_issue_on <= 1'b0;
                end else begin
                    r_phase <= r_phase + 1'b1;
                end
            end
            // completed phases
            if (w_in_xfer) begin
                r_done_cnt <= '0;
            end else if (w_upd) begin
                r_done_cnt <= r_done_cnt + 1'b1;
            end
            // output valid
            if (w_load_out) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // output result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tp_out <= '0;
            r_sp_out <= '0;
        end else if (w_load_out) begin
            r_tp_out <= w_tp;
            r_sp_out <= w_sp;
        end
    end

    assign w_issue_tag.vld   = w_issue;
    assign w_issue_tag.phase = r_phase;

    // chain of tap cells
    for (genvar gj = 0; gj < HistLen; gj++) begin : g_cell
        if (gj == 0) begin : g_first
            tpm_cell #(
                .TAPS     (TAPS),
                .UPSAMPLE (UPSAMPLE),
                .CELL_IDX (gj),
                .ACC_W    (AccW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_in_xfer),
                .i_hist  (i_sample),
                .o_hist  (w_hist[gj]),
                .i_sum   ('0),
                .i_tag   (w_issue_tag),
                .o_sum   (w_sum[gj]),
                .o_tag   (w_tag[gj])
            );
        end else begin : g_next
            tpm_cell #(
                .TAPS     (TAPS),
                .UPSAMPLE (UPSAMPLE),
                .CELL_IDX (gj),
                .ACC_W    (AccW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_in_xfer),
                .i_hist  (w_hist[gj-1]),
                .o_hist  (w_hist[gj]),
                .i_sum   (w_sum[gj-1]),
                .i_tag   (w_tag[gj-1]),
                .o_sum   (w_sum[gj]),
                .o_tag   (w_tag[gj])
            );
        end
    end

    // peak tracking
    tpm_peak #(
        .ACC_W (AccW)
    ) u_peak (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_sum         (w_sum[HistLen-1]),
        .i_sum_vld     (w_tag[HistLen-1].vld),
        .i_smag        (w_smag),
        .i_smag_vld    (w_in_xfer),
        .o_true_peak   (w_tp),
        .o_sample_peak (w_sp),
        .o_upd         (w_upd)
    );

    assign o_valid       = r_o_valid;
    assign o_true_peak   = r_tp_out;
    assign o_sample_peak = r_sp_out;

`ifndef SYNTHESIS
    // true peak never falls below the sample peak in a result
    a_tp_ge_sp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_true_peak >= {1'b0, o_sample_peak}))
        else $error("true peak below sample peak");

    // running true peak never decreases outside reset
    a_tp_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (w_tp >= $past(w_tp)))
        else $error("true peak decreased");

    // no phase completes while the block is idle
    a_no_idle_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tpm_pkg::ST_IDLE) |-> !w_upd)
        else $error("phase completed while idle");

    // the last phase of the sample always puts the block into the done state
    a_load_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last_upd |=> (r_state == tpm_pkg::ST_DONE))
        else $error("result not pending after last phase");
`endif

endmodule

// ----- sim/true_peak_meter_polyphase_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// true_peak_meter_polyphase_tb
// Self-checking bench for the polyphase true-peak meter. Samples go in over
// a valid/ready transfer and the running true and sample peaks coming out
// are compared with a local polyphase sinc interpolator. Traffic is a short
// directed set, amplitude-ramped random samples under varying sender gaps
// and receiver stalls with a long receiver hold-off, and a full-scale pattern.
// ----------------------------------------------------------------------------
module true_peak_meter_polyphase_tb;

    localparam int TAPS     = tpm_pkg::TAPS_DEF;
    localparam int UP       = tpm_pkg::UPSAMPLE_DEF;
    localparam int SAMPLE_W = tpm_pkg::SAMPLE_W;
    localparam int TP_W     = tpm_pkg::TP_W;
    localparam int SP_W     = tpm_pkg::SP_W;
    localparam int HLEN     = (TAPS + UP - 1) / UP;
    localparam int LATENCY  = UP + 2 * HLEN + 3;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // random part: four idling phases plus the hold-off burst
    localparam int PHASE_ITEMS = 170;
    localparam int HOLD_ITEMS  = 6;
    localparam int HOLD_CYCLES = 500;
    localparam int RAND_ITEMS  = 4 * PHASE_ITEMS + HOLD_ITEMS;

    typedef struct packed {
        logic [TP_W-1:0] true_peak;
        logic [SP_W-1:0] sample_peak;
    } t_peak_pair;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_ready;
    logic signed [SAMPLE_W-1:0] i_sample;
    logic                       o_valid;
    logic                       i_ready;
    logic [TP_W-1:0]            o_true_peak;
    logic [SP_W-1:0]            o_sample_peak;

    // interpolator state
    longint signed              sinc_coef [TAPS];
    logic signed [SAMPLE_W-1:0] sample_hist [HLEN];
    logic [TP_W-1:0]            tp_run;
    logic [SP_W-1:0]            sp_run;
    t_peak_pair                 expected_peaks [$];

    int                         err_count    = 0;
    int                         tx_idle_pct  = 0;
    int                         rx_stall_pct = 0;
    int                         hold_req     = 0;
    int                         hold_left    = 0;
    int                         rand_count   = 0;
    int                         last_sample  = 0;

    true_peak_meter_polyphase #(
        .TAPS     (TAPS),
        .UPSAMPLE (UP)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_sample      (i_sample),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_true_peak   (o_true_peak),
        .o_sample_peak (o_sample_peak)
    );

    always #5 i_clk = ~i_clk;

    // unwindowed sinc tap c in Q2.16, sine taken from a Q30 series
    function automatic longint signed sinc_coef_q16(input int c);
        longint unsigned a;
        longint unsigned m;
        longint unsigned x;
        longint unsigned t;
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        longint signed   s;
        int              k;
        logic            neg;
        k   = c - (TAPS - 1) / 2;
        neg = 1'b0;
        if (k == 0) begin
            return 65536;
        end
        a = (k < 0) ? -k : k;
        if (a > (TAPS - 1) / 2) begin
            return 0;
        end
        // fold the angle into the first quarter, remembering the sign
        m = a % (2 * UP);
        if (m >= UP) begin
            m   = m - UP;
            neg = 1'b1;
        end
        if (2 * m > UP) begin
            m = UP - m;
        end
        x = (tpm_pkg::PI_Q30 * m + UP / 2) / UP;
        t = x;
        s = x;
        for (int n = 1; n <= 10; n++) begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / ((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
                s = s - t;
            end else begin
                s = s + t;
            end
        end
        if (s < 0) begin
            s = 0;
        end
        num = (UP * s) << 16;
        den = tpm_pkg::PI_Q30 * a;
        q   = (2 * num + den) / (2 * den);
        return neg ? -longint'(q) : longint'(q);
    endfunction

    // shift one sample in, run every phase and queue the updated peaks
    function automatic void predict_peaks(input logic signed [SAMPLE_W-1:0] s);
        longint signed   acc;
        longint unsigned mag;
        longint unsigned smag;
        t_peak_pair      pair;
        for (int i = HLEN - 1; i > 0; i--) begin
            sample_hist[i] = sample_hist[i-1];
        end
        sample_hist[0] = s;
        smag = (s < 0) ? -longint'(s) : longint'(s);
        for (int p = 0; p < UP; p++) begin
            acc = 0;
            for (int j = 0; j < HLEN && p + j * UP < TAPS; j++) begin
                acc += sinc_coef[p + j * UP] * longint'(sample_hist[j]);
            end
            mag = (acc < 0) ? -acc : acc;
            mag = (mag + 32768) >> 16;
            if (mag > tpm_pkg::TP_MAX) begin
                mag = tpm_pkg::TP_MAX;
            end
            if (mag > tp_run) begin
                tp_run = mag[TP_W-1:0];
            end
        end
        if (smag > tp_run) begin
            tp_run = smag[TP_W-1:0];
        end
        if (smag > sp_run) begin
            sp_run = smag[SP_W-1:0];
        end
        pair.true_peak   = tp_run;
        pair.sample_peak = sp_run;
        expected_peaks.insert(expected_peaks.size(), pair);
    endfunction

    // random sample whose amplitude grows over the run, so the peaks keep moving
    function automatic logic signed [SAMPLE_W-1:0] next_test_sample();
        int w;
        int amp;
        int v;
        w = 1 + (rand_count * (SAMPLE_W - 1)) / RAND_ITEMS;
        if (w > SAMPLE_W) begin
            w = SAMPLE_W;
        end
        amp = 1 << (w - 1);
        case ($urandom_range(0, 3))
            0, 1: begin
                v = int'($urandom_range(0, 2 * amp - 1)) - amp;
            end
            2: begin
                // near-nyquist alternation gives large inter-sample overshoot
                if (rand_count % 2 == 1) begin
                    v = amp - 1 - int'($urandom_range(0, amp / 4));
                end else begin
                    v = -amp + int'($urandom_range(0, amp / 4));
                end
            end
            default: begin
                v = last_sample;
            end
        endcase
        rand_count++;
        last_sample = v;
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        err_count++;
    endtask

    // offer one sample, optionally after a gap, and return once it is taken;
    // valid is left high so a following call continues the stream seamlessly
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 2 * LATENCY)) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        predict_peaks(s);
    endtask

    // receiver: random stalls, or a counted hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // compare every output transfer with the oldest predicted pair
    always @(posedge i_clk) begin : check_results
        t_peak_pair want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
            if (expected_peaks.size() == 0) begin
                report_mismatch($sformatf("result with none pending: tp=%0d sp=%0d",
                                          o_true_peak, o_sample_peak));
            end else begin
                want = expected_peaks.pop_front();
                if (o_true_peak !== want.true_peak) begin
                    report_mismatch($sformatf("true_peak got %0d want %0d",
                                              o_true_peak, want.true_peak));
                end
                if (o_sample_peak !== want.sample_peak) begin
                    report_mismatch($sformatf("sample_peak got %0d want %0d",
                                              o_sample_peak, want.sample_peak));
                end
            end
        end
    end

    // zero, smallest magnitudes of both signs
    task automatic test_small_values();
        send_sample('0);
        send_sample(SAMPLE_W'(1));
        send_sample(SAMPLE_W'(-1));
        send_sample(SAMPLE_W'(-2));
    endtask

    // single pulse followed by silence walks it down the history line
    task automatic test_impulse();
        send_sample(SAMPLE_W'(3000));
        repeat (6) send_sample('0);
    endtask

    task automatic test_random_traffic(input int n, input int tx_pct, input int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (n) send_sample(next_test_sample());
    endtask

    // receiver holds off for a long stretch while samples keep coming,
    // so the output register fills and the input side backs up
    task automatic test_receiver_hold_off();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_req     = HOLD_CYCLES;
        repeat (HOLD_ITEMS) send_sample(next_test_sample());
    endtask

    // full-scale samples signed to match the strongest phase: drives the
    // interpolated value to its ceiling and uses both sample extremes
    task automatic test_worst_case_pattern();
        longint signed best_sum;
        longint signed sum;
        int            best_ph;
        int            c;
        best_sum = -1;
        best_ph  = 0;
        for (int p = 0; p < UP; p++) begin
            sum = 0;
            for (int j = 0; j < HLEN && p + j * UP < TAPS; j++) begin
                c = p + j * UP;
                sum += (sinc_coef[c] < 0) ? -sinc_coef[c] : sinc_coef[c];
            end
            if (sum > best_sum) begin
                best_sum = sum;
                best_ph  = p;
            end
        end
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        for (int n = 0; n < HLEN; n++) begin
            c = best_ph + (HLEN - 1 - n) * UP;
            send_sample((c < TAPS && sinc_coef[c] < 0) ? SAMPLE_MIN : SAMPLE_MAX);
        end
    endtask

    initial begin
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_sample = '0;
        i_ready  = 1'b0;
        for (int c = 0; c < TAPS; c++) begin
            sinc_coef[c] = sinc_coef_q16(c);
        end
        for (int i = 0; i < HLEN; i++) begin
            sample_hist[i] = '0;
        end
        tp_run = '0;
        sp_run = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_small_values();
        test_impulse();
        test_random_traffic(PHASE_ITEMS, 0, 0);
        test_random_traffic(PHASE_ITEMS, 58, 0);
        test_receiver_hold_off();
        test_random_traffic(PHASE_ITEMS, 0, 58);
        test_random_traffic(PHASE_ITEMS, 37, 37);
        test_worst_case_pattern();

        // drain, then allow for anything stray to appear
        i_valid <= 1'b0;
        while (expected_peaks.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("[true_peak_meter_polyphase] OK");
        end else begin
            $display("[true_peak_meter_polyphase] ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("[true_peak_meter_polyphase] ERROR");
        $finish;
    end

endmodule
